// ===== sv/erse_pkg.sv =====
// shared constants, types and command/status structs for the rpm estimator
package erse_pkg;

    // history ring (depth must be a power of two)
    localparam int HIST_DEPTH = 16;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // field widths
    localparam int SCALE_W   = 40;
    localparam int TMO_W     = 24;
    localparam int TIME_W    = 32;
    localparam int PWM_W     = 8;
    localparam int RPM_W     = 24;
    localparam int PEAK_W    = 23;
    localparam int CNT_W     = 4;

    // accumulator and divider widths
    localparam int SUM_W     = SCALE_W + HIST_AW + 1;
    localparam int PSUM_W    = PWM_W + HIST_AW;
    localparam int DIV_CW    = $clog2(SUM_W + 1);

    // item kinds
    localparam logic [1:0] MODE_EDGE  = 2'd0;
    localparam logic [1:0] MODE_STALL = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // direction codes stored in the ring
    localparam logic [1:0] DIR_ZERO = 2'b00;
    localparam logic [1:0] DIR_FWD  = 2'b01;
    localparam logic [1:0] DIR_REV  = 2'b11;

    // register indexes
    localparam logic REG_RPM_SCALE = 1'b0;
    localparam logic REG_TIMEOUT   = 1'b1;

    // reset values and tuning constants
    localparam logic [SCALE_W-1:0] RPM_SCALE_RST = 40'd23272727;
    localparam logic [TMO_W-1:0]   TIMEOUT_RST   = 24'd100000;
    localparam logic [PEAK_W-1:0]  PEAK_RST      = 23'd17920;
    localparam logic [PWM_W-1:0]   THR_RST       = 8'd50;
    localparam logic [PWM_W-1:0]   THR_FLOOR     = 8'd30;
    localparam logic [PWM_W-1:0]   THR_MAX       = 8'd255;
    localparam int                 THR_RISE      = 7;
    localparam int                 THR_FALL      = 2;
    localparam int                 THR_MARGIN    = 25;
    localparam int                 LOW_OFFSET    = 50;
    localparam logic [PWM_W-1:0]   PWM_FULL      = 8'd230;
    localparam logic [TIME_W-1:0]  DT_MIN        = 32'd10;
    localparam int                 DECAY_KEEP    = 243;
    localparam int                 DECAY_ADD     = 13;

    // divider operand select
    typedef enum logic [1:0] {
        DIV_RATE,
        DIV_AVG,
        DIV_PWM
    } div_op_t;

    // controller to datapath
    typedef struct packed {
        logic    take;
        logic    div_start;
        div_op_t div_op;
        logic    skip;
        logic    acc;
        logic    avg_latch;
        logic    peak;
    } erse_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic win_out;
        logic dt_big;
        logic last_step;
        logic div_done;
        logic n_zero;
    } erse_stat_t;

endpackage

// ===== sv/encoder_rpm_estimator_stall_adapt_core.sv =====
// top level: stream ports, register port, controller and datapath
// An encoder edge, a stall check or an undefined kind gives its result word
// in the cycle after acceptance. A query walks back through the 16-entry event
// ring one interval per step: an interval that is skipped takes a single step,
// and one that counts waits for the bit-serial divider (one quotient bit per
// cycle over 45 bits); averaging adds two more divider passes. One item is in
// work at a time; the result word sits in an output register, and the next
// item is taken in the same cycle that the waiting result is taken.
module encoder_rpm_estimator_stall_adapt_core
    import erse_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // slave side
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // timestamp_us[31:0], drive_pwm[39:32], drive_dir[40],
                                    // window_us[72:41], zero[79:73]
    input  logic [1:0]   s_tuser,   // mode[1:0]
    // master side
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // rpm[23:0], max_rpm[46:24], position_count[78:47],
                                    // no_speed[86:79], low_speed[94:87], jump_start[95],
                                    // stalled[96], sample_count[100:97], zero[103:101]
    // register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    erse_cmd_t                cmd;
    erse_stat_t               stat;
    logic [SCALE_W-1:0]       scale_reg;
    logic [TMO_W-1:0]         tmo_reg;
    logic                     reg_sel;
    logic signed [RPM_W-1:0]  rpm;
    logic [PEAK_W-1:0]        max_rpm;
    logic signed [TIME_W-1:0] position_count;
    logic [PWM_W-1:0]         no_speed;
    logic [PWM_W-1:0]         low_speed;
    logic                     jump_start;
    logic                     stalled;
    logic [CNT_W-1:0]         sample_count;

    // configuration registers
    assign reg_sel = paddr[3];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= RPM_SCALE_RST;
            tmo_reg   <= TIMEOUT_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_sel)
                REG_RPM_SCALE: scale_reg <= pwdata[SCALE_W-1:0];
                REG_TIMEOUT:   tmo_reg   <= pwdata[TMO_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign prdata = (reg_sel == REG_TIMEOUT) ? {40'b0, tmo_reg} : {24'b0, scale_reg};

    erse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_mode   (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    erse_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .mode             (s_tuser),
        .timestamp_us     (s_tdata[31:0]),
        .drive_pwm        (s_tdata[39:32]),
        .drive_dir        (s_tdata[40]),
        .window_us        (s_tdata[72:41]),
        .rpm_scale        (scale_reg),
        .speed_timeout_us (tmo_reg),
        .rpm              (rpm),
        .max_rpm          (max_rpm),
        .position_count   (position_count),
        .no_speed         (no_speed),
        .low_speed        (low_speed),
        .jump_start       (jump_start),
        .stalled          (stalled),
        .sample_count     (sample_count)
    );

    // result word
    assign m_tdata = {3'b0, sample_count, stalled, jump_start, low_speed, no_speed,
                      position_count, max_rpm, rpm};

endmodule

// ===== sv/erse_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module erse_div
    import erse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SUM_W-1:0]  dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic [SUM_W-1:0]  quotient,
    output logic              done
);

    logic [TIME_W-1:0] rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [TIME_W-1:0] dsr_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [TIME_W:0]   shifted;
    logic [TIME_W:0]   trial;

    // one shift-subtract step
    assign shifted = {rem_reg, quo_reg[SUM_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CW'(SUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[TIME_W])
            begin
                rem_reg <= trial[TIME_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[TIME_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== sv/erse_dp.sv =====
// datapath: event ring, position and threshold state, query accumulation
module erse_dp
    import erse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  erse_cmd_t                cmd,
    output erse_stat_t               stat,
    input  logic [1:0]               mode,
    input  logic [TIME_W-1:0]        timestamp_us,
    input  logic [PWM_W-1:0]         drive_pwm,
    input  logic                     drive_dir,
    input  logic [TIME_W-1:0]        window_us,
    input  logic [SCALE_W-1:0]       rpm_scale,
    input  logic [TMO_W-1:0]         speed_timeout_us,
    output logic signed [RPM_W-1:0]  rpm,
    output logic [PEAK_W-1:0]        max_rpm,
    output logic signed [TIME_W-1:0] position_count,
    output logic [PWM_W-1:0]         no_speed,
    output logic [PWM_W-1:0]         low_speed,
    output logic                     jump_start,
    output logic                     stalled,
    output logic [CNT_W-1:0]         sample_count
);

    // event ring
    logic [TIME_W-1:0]  time_mem [HIST_DEPTH];
    logic [1:0]         dir_mem  [HIST_DEPTH];
    logic [PWM_W-1:0]   pwm_mem  [HIST_DEPTH];

    logic [HIST_AW-1:0] ws_reg;
    logic [TIME_W-1:0]  edge_reg;
    logic [PEAK_W-1:0]  peak_reg;
    logic [PWM_W-1:0]   thr_reg;
    logic               kick_reg;
    logic               stalled_reg;
    logic [RPM_W-1:0]   rpm_reg;
    logic [HIST_AW-1:0] n_reg;

    // query working registers
    logic [TIME_W-1:0]  now_reg;
    logic [TIME_W-1:0]  win_reg;
    logic [HIST_AW-1:0] s_reg;
    logic [TIME_W-1:0]  cur_time_reg;
    logic [1:0]         cur_dir_reg;
    logic [PWM_W-1:0]   cur_pwm_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [PSUM_W-1:0]  psum_reg;
    logic [PEAK_W-1:0]  mag_reg;

    logic [HIST_AW-1:0] prev_idx;
    logic [HIST_AW-1:0] j_idx;
    logic [TIME_W-1:0]  prev_time;
    logic [TIME_W-1:0]  stall_gap;
    logic               is_stall;
    logic [PWM_W:0]     thr_up;
    logic [PWM_W:0]     thr_margin;
    logic [PWM_W:0]     low_sum;
    logic [TIME_W-1:0]  dt;
    logic [TIME_W-1:0]  age;
    logic [SUM_W-1:0]   abs_sum;
    logic [SUM_W-1:0]   div_dividend;
    logic [TIME_W-1:0]  div_divisor;
    logic [SUM_W-1:0]   div_q;
    logic               div_done;
    logic [SUM_W-1:0]   acc_term;
    logic [PSUM_W-1:0]  mean_pwm;
    logic [PEAK_W+8:0]  decay_mix;

    // ring addressing
    assign prev_idx  = ws_reg - 1'b1;
    assign j_idx     = ws_reg - s_reg - 1'b1;
    assign prev_time = time_mem[prev_idx];

    // stall check arithmetic
    assign stall_gap  = timestamp_us - prev_time;
    assign is_stall   = stall_gap >= {{(TIME_W-TMO_W){1'b0}}, speed_timeout_us};
    assign thr_up     = {1'b0, thr_reg} + (PWM_W+1)'(THR_RISE);
    assign thr_margin = {1'b0, thr_reg} + (PWM_W+1)'(THR_MARGIN);
    assign low_sum    = {1'b0, thr_reg} + (PWM_W+1)'(LOW_OFFSET);

    // query step status
    assign age = now_reg - cur_time_reg;
    assign dt  = cur_time_reg - time_mem[j_idx];

    always_comb
    begin
        stat.win_out   = age > win_reg;
        stat.dt_big    = dt > DT_MIN;
        stat.last_step = s_reg == HIST_AW'(HIST_DEPTH - 1);
        stat.div_done  = div_done;
        stat.n_zero    = n_reg == '0;
    end

    // divider operand select
    assign abs_sum = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;

    always_comb
    begin
        case (cmd.div_op)
            DIV_RATE:
            begin
                div_dividend = {{(SUM_W-SCALE_W){1'b0}}, rpm_scale};
                div_divisor  = dt;
            end
            DIV_AVG:
            begin
                div_dividend = abs_sum;
                div_divisor  = {{(TIME_W-HIST_AW){1'b0}}, n_reg};
            end
            DIV_PWM:
            begin
                div_dividend = {{(SUM_W-PSUM_W){1'b0}}, psum_reg};
                div_divisor  = {{(TIME_W-HIST_AW){1'b0}}, n_reg};
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    erse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_q),
        .done     (div_done)
    );

    // signed contribution of one interval
    always_comb
    begin
        case (cur_dir_reg)
            DIR_FWD: acc_term = div_q;
            DIR_REV: acc_term = ~div_q + 1'b1;
            default: acc_term = '0;
        endcase
    end

    assign mean_pwm  = div_q[PSUM_W-1:0];
    assign decay_mix = (PEAK_W+9)'(DECAY_KEEP) * {9'b0, peak_reg}
                     + (PEAK_W+9)'(DECAY_ADD) * {9'b0, mag_reg};

    // event ring writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                time_mem[k] <= '0;
                dir_mem[k]  <= DIR_ZERO;
                pwm_mem[k]  <= '0;
            end
        end
        else if (cmd.take && (mode == MODE_EDGE || (mode == MODE_STALL && is_stall)))
        begin
            time_mem[ws_reg] <= timestamp_us;
            pwm_mem[ws_reg]  <= drive_pwm;
            if (mode == MODE_STALL)
                dir_mem[ws_reg] <= DIR_ZERO;
            else
                dir_mem[ws_reg] <= drive_dir ? DIR_FWD : DIR_REV;
        end
    end

    // persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg      <= '0;
            edge_reg    <= '0;
            peak_reg    <= PEAK_RST;
            thr_reg     <= THR_RST;
            kick_reg    <= 1'b1;
            stalled_reg <= 1'b0;
            rpm_reg     <= '0;
            n_reg       <= '0;
            s_reg       <= '0;
        end
        else if (cmd.take)
        begin
            stalled_reg <= 1'b0;
            rpm_reg     <= '0;
            n_reg       <= '0;
            s_reg       <= HIST_AW'(1);
            case (mode)
                MODE_EDGE:
                begin
                    ws_reg   <= ws_reg + 1'b1;
                    edge_reg <= drive_dir ? edge_reg + 1'b1 : edge_reg - 1'b1;
                end
                MODE_STALL:
                begin
                    if (is_stall)
                    begin
                        ws_reg      <= ws_reg + 1'b1;
                        kick_reg    <= 1'b1;
                        stalled_reg <= 1'b1;
                        if (drive_pwm > thr_reg)
                            thr_reg <= thr_up[PWM_W] ? THR_MAX : thr_up[PWM_W-1:0];
                    end
                    else if ({1'b0, drive_pwm} < thr_margin)
                    begin
                        thr_reg <= (thr_reg < THR_FLOOR + PWM_W'(THR_FALL)) ? THR_FLOOR
                                   : thr_reg - PWM_W'(THR_FALL);
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            if (cmd.skip || cmd.acc)
                s_reg <= s_reg + 1'b1;
            if (cmd.acc)
                n_reg <= n_reg + 1'b1;
            if (cmd.avg_latch)
            begin
                if (sum_reg[SUM_W-1])
                    rpm_reg <= (div_q > SUM_W'(24'h800000)) ? 24'h800000
                               : ~div_q[RPM_W-1:0] + 1'b1;
                else
                    rpm_reg <= (div_q > SUM_W'(24'h7FFFFF)) ? 24'h7FFFFF
                               : div_q[RPM_W-1:0];
            end
            if (cmd.peak)
            begin
                if (mag_reg > peak_reg)
                    peak_reg <= mag_reg;
                else if (mean_pwm > PSUM_W'(PWM_FULL))
                    peak_reg <= decay_mix[PEAK_W+7:8];
            end
        end
    end

    // query working registers
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            now_reg      <= timestamp_us;
            win_reg      <= window_us;
            cur_time_reg <= prev_time;
            cur_dir_reg  <= dir_mem[prev_idx];
            cur_pwm_reg  <= pwm_mem[prev_idx];
            sum_reg      <= '0;
            psum_reg     <= '0;
        end
        else
        begin
            if (cmd.acc)
            begin
                sum_reg      <= sum_reg + acc_term;
                psum_reg     <= psum_reg + {{HIST_AW{1'b0}}, cur_pwm_reg};
                cur_time_reg <= time_mem[j_idx];
                cur_dir_reg  <= dir_mem[j_idx];
                cur_pwm_reg  <= pwm_mem[j_idx];
            end
            if (cmd.avg_latch)
                mag_reg <= (div_q > SUM_W'(23'h7FFFFF)) ? 23'h7FFFFF : div_q[PEAK_W-1:0];
        end
    end

    // result fields
    assign rpm            = rpm_reg;
    assign max_rpm        = peak_reg;
    assign position_count = edge_reg;
    assign no_speed       = thr_reg;
    assign low_speed      = low_sum[PWM_W] ? THR_MAX : low_sum[PWM_W-1:0];
    assign jump_start     = kick_reg;
    assign stalled        = stalled_reg;
    assign sample_count   = (n_reg > HIST_AW'(15)) ? 4'd15 : CNT_W'(n_reg);

endmodule

// ===== sv/erse_ctrl.sv =====
// controller: handshakes and sequencing of the query walk
module erse_ctrl
    import erse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_mode,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output erse_cmd_t  cmd,
    input  erse_stat_t stat
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK,
        ST_RDIV,
        ST_AVG,
        ST_AWAIT,
        ST_PWM,
        ST_PWAIT,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ov_reg;
    logic   ov_next;
    logic   out_free;
    logic   take;

    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign take     = in_valid && in_ready;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        ov_next       = ov_reg && !out_ready;
        cmd           = '0;
        cmd.div_op    = DIV_RATE;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cmd.take = 1'b1;
                    if (in_mode == MODE_QUERY)
                        state_next = ST_CHK;
                    else
                        ov_next = 1'b1;
                end
            end
            ST_CHK:
            begin
                if (stat.win_out)
                    state_next = stat.n_zero ? ST_FIN : ST_AVG;
                else if (stat.dt_big)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_RDIV;
                end
                else
                begin
                    cmd.skip = 1'b1;
                    if (stat.last_step)
                        state_next = stat.n_zero ? ST_FIN : ST_AVG;
                end
            end
            ST_RDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.acc    = 1'b1;
                    state_next = stat.last_step ? ST_AVG : ST_CHK;
                end
            end
            ST_AVG:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_AVG;
                state_next    = ST_AWAIT;
            end
            ST_AWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.avg_latch = 1'b1;
                    state_next    = ST_PWM;
                end
            end
            ST_PWM:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_PWM;
                state_next    = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.peak   = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

// ===== sv/erse_checker.sv =====
// port-level checks for the rpm estimator, bound to the top level
module erse_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);

    // result word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    // no new word taken while a result waits unclaimed
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result blocked");

    // low threshold follows the stall threshold
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[86:79] >= 8'd205 && m_tdata[94:87] == 8'd255) ||
                      (m_tdata[86:79] < 8'd205 && m_tdata[94:87] == m_tdata[86:79] + 8'd50)))
        else $error("low_speed mismatch");

    // no samples means zero rpm
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[100:97] == 4'd0 |-> m_tdata[23:0] == 24'd0)
        else $error("rpm nonzero without samples");

    // a stall word counts no samples
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[96] |-> m_tdata[100:97] == 4'd0 && m_tdata[95])
        else $error("stall word inconsistent");

endmodule

bind encoder_rpm_estimator_stall_adapt_core erse_checker u_erse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/tb_top.sv =====
// testbench for the encoder rpm estimator: stream stimulus, scoreboard and register writes
module tb_top;
    import erse_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;   // timestamp_us[31:0], drive_pwm[39:32], drive_dir[40], window_us[72:41]
    logic [1:0]   s_tuser;   // mode[1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;   // rpm, max_rpm, position_count, no_speed, low_speed,
                             // jump_start, stalled, sample_count
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    encoder_rpm_estimator_stall_adapt_core uut (.*);

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] ts;
        logic [7:0]  pwm;
        logic        fwd;
        logic [31:0] win;
    } enc_word_t;

    // predictor state
    logic [39:0] scale_q;
    logic [23:0] tmo_q;
    logic [31:0] ring_t [HIST_DEPTH];
    int          ring_d [HIST_DEPTH];
    logic [7:0]  ring_p [HIST_DEPTH];
    int unsigned slot_q;
    logic [31:0] pos_q;
    logic [22:0] peak_q;
    logic [7:0]  thr_q;
    logic        kick_q;

    enc_word_t    pending_words[$];
    logic [103:0] expected_words[$];
    int           errors = 0;
    int           n_results = 0;
    int           n_queries_hit = 0;
    longint       cycles = 0;
    logic [31:0]  tnow;

    always
    begin
        clk = 1'b1; #5;
        clk = 1'b0; #5;
    end

    function automatic int unsigned back_idx(int unsigned b);
        return (slot_q + 2 * HIST_DEPTH - b) % HIST_DEPTH;
    endfunction

    function automatic void push_event(logic [31:0] t, int d, logic [7:0] p);
        ring_t[slot_q] = t;
        ring_d[slot_q] = d;
        ring_p[slot_q] = p;
        slot_q = (slot_q + 1) % HIST_DEPTH;
    endfunction

    // compute the result word of one item and update the shadow state
    function automatic logic [103:0] predict_rpm_word(enc_word_t w);
        longint      rpm_o = 0;
        int unsigned n = 0, ns = 0, pws = 0, mean;
        logic        stl = 1'b0;
        logic [31:0] tc [HIST_DEPTH];
        int          dc [HIST_DEPTH];
        logic [7:0]  pc [HIST_DEPTH];
        longint      sum = 0, avg, a;
        logic [31:0] dt;
        int unsigned i, j, mag, lowv;
        if (w.mode == MODE_EDGE)
        begin
            push_event(w.ts, w.fwd ? 1 : -1, w.pwm);
            pos_q = w.fwd ? pos_q + 1 : pos_q - 1;
        end
        else if (w.mode == MODE_STALL)
        begin
            if (32'(w.ts - ring_t[back_idx(1)]) >= {8'd0, tmo_q})
            begin
                push_event(w.ts, 0, w.pwm);
                if (w.pwm > thr_q)
                    thr_q = (int'(thr_q) + 7 > 255) ? 8'd255 : thr_q + 8'd7;
                kick_q = 1'b1;
                stl = 1'b1;
            end
            else if (int'(w.pwm) < int'(thr_q) + 25)
                thr_q = (thr_q < 32) ? 8'd30 : thr_q - 8'd2;
        end
        else if (w.mode == MODE_QUERY)
        begin
            tc = ring_t; dc = ring_d; pc = ring_p;
            for (int unsigned s = 1; s < HIST_DEPTH; s++)
            begin
                i = back_idx(s);
                j = back_idx(s + 1);
                dt = tc[i] - tc[j];
                if (32'(w.ts - tc[i]) > w.win)
                    break;
                if (dt > 10)
                begin
                    sum += longint'(dc[i]) * longint'({24'd0, scale_q} / {32'd0, dt});
                    pws += pc[i];
                    n++;
                end
                else
                begin
                    tc[j] = tc[i]; dc[j] = dc[i]; pc[j] = pc[i];
                end
            end
            if (n > 0)
            begin
                avg = sum / longint'(n);
                a = avg < 0 ? -avg : avg;
                mag = (a > 8388607) ? 8388607 : int'(a);
                mean = pws / n;
                if (mag > peak_q)
                    peak_q = 23'(mag);
                else if (mean > 230)
                    peak_q = 23'((243 * longint'(peak_q) + 13 * longint'(mag)) >> 8);
                if (avg > 8388607) avg = 8388607;
                if (avg < -8388608) avg = -8388608;
                rpm_o = avg;
                ns = n > 15 ? 15 : n;
            end
        end
        lowv = (int'(thr_q) + 50 > 255) ? 255 : int'(thr_q) + 50;
        return {3'd0, 4'(ns), stl, kick_q, 8'(lowv), thr_q, pos_q, peak_q, 24'(rpm_o)};
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        enc_word_t w;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                w = pending_words.pop_front();
                expected_words.push_back(predict_rpm_word(w));
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    w = pending_words[0];
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, w.win, w.fwd, w.pwm, w.ts};
                    s_tuser  <= w.mode;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and checker
    int stall_phase = 0;
    always @(posedge clk)
    begin
        logic [103:0] e;
        cycles <= cycles + 1;
        if (rst_n)
        begin
            stall_phase <= (stall_phase + 1) % 97;
            m_tready <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
            if (m_tvalid && m_tready)
            begin
                n_results <= n_results + 1;
                if (expected_words.size() == 0)
                begin
                    errors <= errors + 1;
                    $display("%0t unexpected word %h", $time, m_tdata);
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (e[100:97] != 0) n_queries_hit <= n_queries_hit + 1;
                    if (e !== m_tdata)
                    begin
                        errors <= errors + 1;
                        $display("%0t mismatch expected %h actual %h", $time, e, m_tdata);
                        if (e[23:0] !== m_tdata[23:0])
                            $display("  rpm expected %h actual %h", e[23:0], m_tdata[23:0]);
                        if (e[46:24] !== m_tdata[46:24])
                            $display("  max_rpm expected %h actual %h", e[46:24], m_tdata[46:24]);
                        if (e[78:47] !== m_tdata[78:47])
                            $display("  position expected %h actual %h", e[78:47], m_tdata[78:47]);
                        if (e[100:79] !== m_tdata[100:79])
                            $display("  flags expected %h actual %h", e[100:79], m_tdata[100:79]);
                    end
                end
            end
        end
        if (cycles > 3000000)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_tvalid || expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic reg_write(logic [3:0] addr, logic [63:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == 4'd0) scale_q = val[39:0];
        else tmo_q = val[23:0];
    endtask

    function automatic void add_word(logic [1:0] m, logic [31:0] t, logic [7:0] p,
                                     logic f, logic [31:0] wn);
        enc_word_t w;
        w.mode = m; w.ts = t; w.pwm = p; w.fwd = f; w.win = wn;
        pending_words.push_back(w);
    endfunction

    // random phase: mostly rotating edges with occasional stalls and queries
    task automatic random_phase(int cnt);
        int k;
        logic [7:0] pw;
        for (k = 0; k < cnt; k++)
        begin
            pw = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(200, 255));
            case ($urandom_range(0, 19))
                0, 1, 2:
                    add_word(MODE_STALL, tnow + ($urandom_range(0, 1) ? $urandom_range(0, 300)
                             : $urandom), pw, 1'($urandom), $urandom);
                3, 4, 5, 6:
                    add_word(MODE_QUERY, tnow + $urandom_range(0, 50), pw, 1'($urandom),
                             ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20000));
                7:
                    add_word(2'd3, $urandom, 8'($urandom), 1'($urandom), $urandom);
                default:
                begin
                    tnow += ($urandom_range(0, 5) == 0) ? $urandom_range(0, 12)
                            : $urandom_range(11, 3000);
                    add_word(MODE_EDGE, tnow, pw, $urandom_range(0, 7) != 0, $urandom);
                end
            endcase
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        scale_q = RPM_SCALE_RST; tmo_q = TIMEOUT_RST;
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            ring_t[k] = '0; ring_d[k] = 0; ring_p[k] = '0;
        end
        slot_q = 0; pos_q = '0; peak_q = PEAK_RST; thr_q = THR_RST; kick_q = 1'b1;
        tnow = 32'hFFFF_F000;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every kind, short intervals, wrap, zero window
        add_word(MODE_QUERY, 32'd0, 8'd0, 1'b0, 32'd0);
        add_word(MODE_STALL, 32'd5, 8'd255, 1'b1, 32'hFFFF_FFFF);
        add_word(MODE_STALL, 32'hFFFF_FFFF, 8'd255, 1'b0, 32'd0);
        add_word(MODE_EDGE, 32'hFFFF_FFF0, 8'd255, 1'b1, 32'hFFFF_FFFF);
        add_word(MODE_EDGE, 32'hFFFF_FFF5, 8'd240, 1'b1, '0);
        add_word(MODE_EDGE, 32'h0000_0100, 8'd250, 1'b1, '0);
        add_word(MODE_EDGE, 32'h0000_0200, 8'd0, 1'b0, '0);
        add_word(MODE_QUERY, 32'h0000_0210, 8'd0, 1'b0, 32'hFFFF_FFFF);
        add_word(MODE_QUERY, 32'h0000_0210, 8'd0, 1'b0, 32'd0);
        add_word(MODE_STALL, 32'h0000_0300, 8'd0, 1'b0, '0);
        add_word(2'd3, 32'hFFFF_FFFF, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        for (int k = 0; k < 10; k++)
            add_word(MODE_STALL, 32'h0100_0000 * (k + 1), 8'd255, 1'b1, '0);
        add_word(MODE_QUERY, 32'h0A00_0001, 8'd255, 1'b1, 32'hFFFF_FFFF);
        wait_drained();

        random_phase(300);
        wait_drained();
        reg_write(4'd0, 64'hFF_FFFF_FFFF);
        reg_write(4'd8, 64'd1);
        random_phase(300);
        wait_drained();
        reg_write(4'd0, 64'd1);
        reg_write(4'd8, 64'hFF_FFFF);
        random_phase(250);
        wait_drained();
        reg_write(4'd0, 64'd4_000_000_000);
        reg_write(4'd8, 64'd2000);
        random_phase(300);
        wait_drained();
        repeat (1200) @(posedge clk);

        $display("covered %0d result words, %0d queries with samples, four register settings",
                 n_results, n_queries_hit);
        if (errors == 0 && expected_words.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
